// ===== design/frontier_direction_search_assert.svh =====
// assertion macros for the frontier search block
`ifndef FRONTIER_DIRECTION_SEARCH_ASSERT_SVH
`define FRONTIER_DIRECTION_SEARCH_ASSERT_SVH
`define FDS_ASSERT_IMP(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define FDS_ASSERT_NXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

// ===== design/fds_pkg.sv =====
`timescale 1ns / 1ps
package fds_pkg;
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_FRONTIER = 2'd1;
	localparam logic [1:0] OP_DISTANCE = 2'd2;
	localparam logic [1:0] CELL_FREE = 2'd0;
	localparam logic [1:0] CELL_UNSEEN = 2'd1;
	localparam logic [1:0] CELL_WALL = 2'd2;

	// unit step sign per direction: 0 north is +x in the table (cos)
	function automatic logic signed [1:0] dir_dx(input logic [2:0] d);
		unique case (d)
			3'd0, 3'd1, 3'd7: dir_dx = 2'sd1;
			3'd3, 3'd4, 3'd5: dir_dx = -2'sd1;
			default: dir_dx = 2'sd0;
		endcase
	endfunction
	function automatic logic signed [1:0] dir_dy(input logic [2:0] d);
		unique case (d)
			3'd1, 3'd2, 3'd3: dir_dy = 2'sd1;
			3'd5, 3'd6, 3'd7: dir_dy = -2'sd1;
			default: dir_dy = 2'sd0;
		endcase
	endfunction
	function automatic logic diag(input logic [2:0] d);
		diag = d[0];
	endfunction
endpackage

// ===== design/fds_heading.sv =====
`timescale 1ns / 1ps
// heading reduced mod 360 and rounded to a direction by reciprocal multiplication,
// three stages (s1, s2, s3) and an output register; done pulses as dir is loaded
module fds_heading (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [15:0] heading,
	output logic done,
	output logic [2:0] dir
);
	logic [16:0] a_s1, a_s2;
	logic [7:0] q_s2;
	logic [8:0] r_s3;
	logic v_s1, v_s2, v_s3;
	logic [33:0] qprod;
	logic [16:0] qmul;
	logic [8:0] rem;
	logic [18:0] dprod;
	// floor(a/360) as a*ceil(2^25/360) >> 25, exact for a below 381000
	assign qprod = 34'(a_s1) * 34'd93207;
	assign qmul = 17'(q_s2) * 17'd360;
	assign rem = 9'(a_s2 - qmul);
	// floor(x/45) as x*365 >> 14, exact for x below 399
	assign dprod = 19'(10'(r_s3) + 10'd22) * 19'd365;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_s1 <= '0;
			a_s2 <= '0;
			q_s2 <= '0;
			r_s3 <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			done <= 1'b0;
			dir <= 3'd0;
		end else begin
			v_s1 <= start;
			// offset by 360*92 keeps it positive and congruent
			if (start) a_s1 <= 17'(signed'(heading) + 17'sd33120);
			v_s2 <= v_s1;
			a_s2 <= a_s1;
			q_s2 <= qprod[32:25];
			v_s3 <= v_s2;
			r_s3 <= rem;
			done <= v_s3;
			if (v_s3) dir <= dprod[16:14];
		end
	end
endmodule

// ===== design/frontier_direction_search.sv =====
`timescale 1ns / 1ps
// channel  dir  tdata fields (lsb first)                                  tuser
// s_axis   in   operation,cell_x,cell_y,cell_value,robot_x,robot_y,
//               heading_deg,ray_direction                                 -
// m_axis   out  best_direction,dir_score,unknown_cells,
//               first_unknown_distance,all_explored,obstacle_distance     -
// write: the next word can follow at once. distance query: each ray step is an
// address, then one registered grid read on the single read port. frontier query:
// load, heading rounding, then eight rays of such steps, each ray scored at its end.
// after reset a clearing pass writes unknown to all GRID_WIDTH*GRID_HEIGHT cells
// before s_axis_tready rises. a result waits in the output register until taken;
// words are accepted meanwhile, and a later query holds in its last state.
module frontier_direction_search #(
	parameter int GRID_WIDTH = 64,
	parameter int GRID_HEIGHT = 64,
	parameter int MAX_RAY = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [47:0] s_axis_tdata, // operation,cell_x,cell_y,cell_value,robot_x,robot_y,heading_deg,ray_direction
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [31:0] m_axis_tdata // best_direction,dir_score,unknown_cells,first_unknown_distance,all_explored,obstacle_distance
);
	import fds_pkg::*;
	localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW = $clog2(DEPTH);
	localparam int DW = $clog2(MAX_RAY + 1);
	localparam int CW = 12;

	typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_HEAD, ST_ADDR, ST_READ, ST_SCORE, ST_OUT}
		state_t;
	state_t state_q;

	logic [1:0] mem [DEPTH];
	logic [1:0] rd_q;
	logic we;
	logic [AW-1:0] wa, ra;
	logic [1:0] wd;
	logic [AW:0] clr_q;

	logic [1:0] op;
	logic [5:0] in_cx, in_cy, in_rx, in_ry;
	logic [1:0] in_cv;
	logic [2:0] in_rd;
	assign op = s_axis_tdata[1:0];
	assign in_cx = s_axis_tdata[7:2];
	assign in_cy = s_axis_tdata[13:8];
	assign in_cv = s_axis_tdata[15:14];
	assign in_rx = s_axis_tdata[21:16];
	assign in_ry = s_axis_tdata[27:22];
	assign in_rd = s_axis_tdata[46:44];

	logic acc;
	logic out_free;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign acc = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_axis_tvalid || m_axis_tready;

	logic hd_done;
	logic [2:0] hd_dir;
	fds_heading u_head (.clk(clk), .arst_n(arst_n), .start(acc && op == OP_FRONTIER),
		.heading(s_axis_tdata[43:28]), .done(hd_done), .dir(hd_dir));

	logic frontier_q;
	logic [2:0] dir_q, rdir_q;
	logic [5:0] rx_q, ry_q;
	logic [DW-1:0] d_q;
	logic [DW:0] unk_q;
	logic [DW-1:0] first_q;
	logic any_q;
	logic [2:0] bdir_q;
	logic signed [9:0] bscore_q;
	logic [DW:0] bunk_q;
	logic [DW-1:0] bfirst_q;

	// 707*d/1000 as d*707*ceil(2^28/1000) >> 28, exact for d<=255
	logic [DW-1:0] dn;
	logic [39:0] prod;
	logic [CW-1:0] offd;
	logic signed [CW-1:0] nx, ny, offx, offy;
	logic in_grid;
	assign dn = DW'(d_q + 1'b1);
	assign prod = 40'(dn) * 40'd189784252;
	assign offd = diag(dir_q) ? prod[39:28] : CW'(dn);
	assign offx = (dir_dx(dir_q) == 2'sd0) ? '0 :
		(dir_dx(dir_q) == 2'sd1 ? signed'(offd) : -signed'(offd));
	assign offy = (dir_dy(dir_q) == 2'sd0) ? '0 :
		(dir_dy(dir_q) == 2'sd1 ? signed'(offd) : -signed'(offd));
	assign nx = CW'(signed'({1'b0, rx_q})) + offx;
	assign ny = CW'(signed'({1'b0, ry_q})) + offy;
	assign in_grid = (nx >= 0) && (nx < GRID_WIDTH) && (ny >= 0) && (ny < GRID_HEIGHT);

	// score of finished ray
	logic [2:0] tdiff;
	logic [2:0] tabs;
	logic signed [12:0] score;
	logic signed [9:0] sc_sat;
	assign tdiff = dir_q - rdir_q;
	assign tabs = tdiff[2] && tdiff != 3'd4 ? 3'(-tdiff) : tdiff;
	assign score = 13'(unk_q) * 13'sd10 + (13'(MAX_RAY) - 13'(first_q)) * 13'sd2
		- 13'(tabs) * 13'sd3 + ((dir_q == rdir_q) ? 13'sd5 : 13'sd0);
	assign sc_sat = score > 13'sd255 ? 10'sd255 : 10'(score);

	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = CELL_UNSEEN;
		if (state_q == ST_CLEAR) begin
			we = 1'b1;
			wa = clr_q[AW-1:0];
		end else if (acc && op == OP_WRITE && in_cv != 2'd3 &&
			32'(in_cx) < GRID_WIDTH && 32'(in_cy) < GRID_HEIGHT) begin
			we = 1'b1;
			wa = AW'(32'(in_cy) * GRID_WIDTH + 32'(in_cx));
			wd = in_cv;
		end
	end
	assign ra = AW'(32'(ny) * GRID_WIDTH + 32'(nx));

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata <= '0;
			frontier_q <= 1'b0;
			dir_q <= '0; rdir_q <= '0; rx_q <= '0; ry_q <= '0; d_q <= '0;
			unk_q <= '0; first_q <= '0; any_q <= 1'b0; bdir_q <= '0;
			bscore_q <= '0; bunk_q <= '0; bfirst_q <= '0;
		end else begin
			if (state_q == ST_OUT && out_free) m_axis_tvalid <= 1'b1;
			else if (m_axis_tready) m_axis_tvalid <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (acc) begin
					rx_q <= in_rx; ry_q <= in_ry; d_q <= '0;
					unk_q <= '0; first_q <= '0;
					any_q <= 1'b0; bdir_q <= '0; bscore_q <= -10'sd1;
					bunk_q <= '0; bfirst_q <= DW'(MAX_RAY);
					if (op == OP_FRONTIER) begin
						frontier_q <= 1'b1; dir_q <= '0; state_q <= ST_HEAD;
					end else if (op == OP_DISTANCE) begin
						frontier_q <= 1'b0; dir_q <= in_rd; state_q <= ST_ADDR;
					end
				end
				ST_HEAD: if (hd_done) begin
					rdir_q <= hd_dir; state_q <= ST_ADDR;
				end
				ST_ADDR: begin
					if (!in_grid) state_q <= ST_SCORE;
					else state_q <= ST_READ;
				end
				ST_READ: begin
					if (rd_q == CELL_WALL) state_q <= ST_SCORE;
					else begin
						if (rd_q == CELL_UNSEEN) begin
							unk_q <= unk_q + 1'b1;
							if (first_q == '0) first_q <= DW'(d_q + 1'b1);
						end
						d_q <= DW'(d_q + 1'b1);
						if (32'(d_q) + 1 >= MAX_RAY) state_q <= ST_SCORE;
						else state_q <= ST_ADDR;
					end
				end
				ST_SCORE: begin
					if (!frontier_q) begin
						// d_q is steps completed; occupied adds one
						if (rd_q == CELL_WALL && in_grid && 32'(d_q) < MAX_RAY)
							d_q <= DW'(d_q + 1'b1);
						state_q <= ST_OUT;
					end else begin
						if (unk_q != '0) begin
							any_q <= 1'b1;
							if (sc_sat > bscore_q) begin
								bscore_q <= sc_sat; bdir_q <= dir_q;
								bunk_q <= unk_q; bfirst_q <= first_q;
							end
						end
						d_q <= '0; unk_q <= '0; first_q <= '0;
						dir_q <= dir_q + 1'b1;
						state_q <= (dir_q == 3'd7) ? ST_OUT : ST_ADDR;
					end
				end
				ST_OUT: if (out_free) begin
					if (frontier_q)
						m_axis_tdata <= {9'd0, ~any_q, 5'(bfirst_q), 5'(bunk_q),
							bscore_q[8:0], bdir_q};
					else
						m_axis_tdata <= {4'd0, 5'(d_q), 23'd0};
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`include "frontier_direction_search_assert.svh"
	`FDS_ASSERT_IMP(a_no_accept_busy, state_q != ST_IDLE, !s_axis_tready)
	`FDS_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`FDS_ASSERT_NXT(a_data_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	`FDS_ASSERT_IMP(a_clear_no_out, state_q == ST_CLEAR, !m_axis_tvalid)
endmodule
